// ===== rtl/core/bve_pkg.sv =====
// ----------------------------------------------------------------------------
// bve_pkg
// Shared widths, constants, control word layout and the microcode table of
// the battery voltage estimator.
// ----------------------------------------------------------------------------
package bve_pkg;

  // field widths
  localparam int RawW     = 12;
  localparam int CalW     = 12;
  localparam int OffW     = 8;
  localparam int WgtW     = 8;
  localparam int MvW      = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  // datapath widths
  localparam int VddW    = 24;  // 3000 * 4095 fits
  localparam int MulAW   = 24;
  localparam int MulBW   = 25;  // 4095 * 6185 fits
  localparam int ProdW   = MulAW + MulBW;
  localparam int RemW    = RawW;
  localparam int DivSteps = VddW;
  localparam int CntW    = $clog2(DivSteps);
  localparam int PcW     = 4;

  localparam int ADC_BITS_DEF = 12;

  // constants of the conversion
  localparam logic [MulBW-1:0] REF_MV        = MulBW'(3000);
  localparam logic [MulBW-1:0] GAIN_Q12      = MulBW'(6185);
  localparam logic [MvW-1:0]   LOAD_LIMIT_MV = MvW'(1000);
  localparam logic [WgtW:0]    WGT_ONE       = (WgtW+1)'(256);

  localparam logic [CalW-1:0] CAL_RESET = CalW'(1656);
  localparam logic [OffW-1:0] OFF_RESET = OffW'(90);
  localparam logic [WgtW-1:0] WGT_RESET = WgtW'(128);

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAL = 2'd0,
    REG_OFF = 2'd1,
    REG_WGT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_CAL,
    MUL_BAT,
    MUL_VDD,
    MUL_NEW,
    MUL_OLD
  } mul_sel_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_LOOP,
    COND_LOW,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic           in_wait;
    mul_sel_e       mul_sel;
    logic           mul_acc;
    logic           div_load;
    logic           div_step;
    logic           vdd_load;
    logic           est_load;
    logic           filt_blend;
    logic           filt_load;
    logic           out_load;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic filt_low;
  } status_t;

  // program steps
  localparam logic [PcW-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PcW-1:0] STEP_SUPPLY    = 4'd1;
  localparam logic [PcW-1:0] STEP_DIV_LOAD  = 4'd2;
  localparam logic [PcW-1:0] STEP_DIV       = 4'd3;
  localparam logic [PcW-1:0] STEP_VDD       = 4'd4;
  localparam logic [PcW-1:0] STEP_SCALE     = 4'd5;
  localparam logic [PcW-1:0] STEP_EST       = 4'd6;
  localparam logic [PcW-1:0] STEP_CHECK     = 4'd7;
  localparam logic [PcW-1:0] STEP_BLEND_OLD = 4'd8;
  localparam logic [PcW-1:0] STEP_BLEND     = 4'd9;
  localparam logic [PcW-1:0] STEP_LOAD      = 4'd10;
  localparam logic [PcW-1:0] STEP_OUT       = 4'd11;
  localparam logic [PcW-1:0] STEP_LAST      = STEP_OUT;

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '0;
    unique case (pc)
      STEP_IDLE: begin
        c.in_wait = 1'b1;
        c.cond    = COND_NO_IN;
        c.target  = STEP_IDLE;
      end
      STEP_SUPPLY:    c.mul_sel = MUL_CAL;
      STEP_DIV_LOAD:  c.div_load = 1'b1;
      STEP_DIV: begin
        c.div_step = 1'b1;
        c.cond     = COND_LOOP;
        c.target   = STEP_DIV;
      end
      STEP_VDD: begin
        c.vdd_load = 1'b1;
        c.mul_sel  = MUL_BAT;
      end
      STEP_SCALE:     c.mul_sel = MUL_VDD;
      STEP_EST:       c.est_load = 1'b1;
      STEP_CHECK: begin
        c.mul_sel = MUL_NEW;
        c.cond    = COND_LOW;
        c.target  = STEP_LOAD;
      end
      STEP_BLEND_OLD: begin
        c.mul_sel = MUL_OLD;
        c.mul_acc = 1'b1;
      end
      STEP_BLEND: begin
        c.filt_blend = 1'b1;
        c.cond       = COND_ALWAYS;
        c.target     = STEP_OUT;
      end
      STEP_LOAD:      c.filt_load = 1'b1;
      STEP_OUT: begin
        c.out_load = 1'b1;
        c.cond     = COND_OUT_BUSY;
        c.target   = STEP_OUT;
      end
      default:        c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/bve_if.sv =====
// ----------------------------------------------------------------------------
// bve interfaces
// Measurement request, result and register write channels.
// ----------------------------------------------------------------------------
interface bve_in_if;
  logic                         valid;
  logic                         ready;
  logic [bve_pkg::RawW-1:0]     reference_raw;
  logic [bve_pkg::RawW-1:0]     battery_raw;
  modport source (output valid, reference_raw, battery_raw, input ready);
  modport sink   (input valid, reference_raw, battery_raw, output ready);
endinterface

interface bve_out_if;
  logic                     valid;
  logic                     ready;
  logic [bve_pkg::MvW-1:0]  battery_millivolts;
  modport source (output valid, battery_millivolts, input ready);
  modport sink   (input valid, battery_millivolts, output ready);
endinterface

interface bve_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bve_pkg::CfgIdxW-1:0]     index;
  logic [bve_pkg::CfgDataW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bve_sequencer.sv =====
// ----------------------------------------------------------------------------
// bve_sequencer
// Step counter, loop counter and microcode lookup driving the datapath.
// ----------------------------------------------------------------------------
module bve_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bve_pkg::status_t status_i,
  output bve_pkg::ctrl_t   ctrl_o
);

  logic [bve_pkg::PcW-1:0]  pc_q, pc_d;
  logic [bve_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     jump;

  assign ctrl_o = bve_pkg::ucode(pc_q);

  always_comb begin
    case (ctrl_o.cond)
      bve_pkg::COND_ALWAYS:   jump = 1'b1;
      bve_pkg::COND_NO_IN:    jump = !status_i.in_valid;
      bve_pkg::COND_LOOP:     jump = cnt_q != bve_pkg::CntW'(bve_pkg::DivSteps - 1);
      bve_pkg::COND_LOW:      jump = status_i.filt_low;
      bve_pkg::COND_OUT_BUSY: jump = status_i.out_busy;
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_d = ctrl_o.target;
    end else if (pc_q == bve_pkg::STEP_LAST) begin
      pc_d = bve_pkg::STEP_IDLE;
    end else begin
      pc_d = pc_q + bve_pkg::PcW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_o.div_load) begin
      cnt_d = '0;
    end else if (ctrl_o.div_step) begin
      cnt_d = cnt_q + bve_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= bve_pkg::STEP_IDLE;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/battery_voltage_estimator.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_estimator
// Supply-compensated battery voltage with an exponential moving average.
// ----------------------------------------------------------------------------
// One request carries a reference and a battery conversion and yields one
// filtered millivolt result. The supply voltage is found by a restoring
// divider that retires one quotient bit per cycle; a shared multiplier then
// scales the battery reading and blends it into the filter, or the filter is
// reloaded from the estimate when it is below 1000 mV. The result then enters
// the output register once that is free and waits there on the sink. The next
// request is taken in the cycle after the result is handed to the output
// register.
module battery_voltage_estimator #(
  parameter int ADC_BITS = bve_pkg::ADC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bve_cfg_if.sink      cfg_i,
  bve_in_if.sink       in_i,
  bve_out_if.source    out_o
);

  localparam int Shift = 12 + ADC_BITS;
  localparam int SumW  = bve_pkg::ProdW + 1;
  localparam logic [SumW-1:0] MvMax = SumW'({bve_pkg::MvW{1'b1}});

  bve_pkg::ctrl_t   ctrl;
  bve_pkg::status_t status;

  // configuration
  logic [bve_pkg::CalW-1:0] cal_q;
  logic [bve_pkg::OffW-1:0] off_q;
  logic [bve_pkg::WgtW-1:0] wgt_q;

  // datapath
  logic [bve_pkg::RawW-1:0]  ref_q, bat_q;
  logic [bve_pkg::VddW-1:0]  quo_q, vdd_q;
  logic [bve_pkg::RemW-1:0]  rem_q;
  logic [bve_pkg::ProdW-1:0] prod_q;
  logic [bve_pkg::MvW-1:0]   est_q, est_d, filt_q;
  logic [bve_pkg::MvW-1:0]   out_data_q;
  logic                      out_valid_q;

  logic [bve_pkg::MulAW-1:0] mul_a;
  logic [bve_pkg::MulBW-1:0] mul_b;
  logic [bve_pkg::ProdW-1:0] mul_p;
  logic [bve_pkg::RemW:0]    rem_sh;
  logic [bve_pkg::RemW+1:0]  rem_diff;
  logic [SumW-1:0]           est_sum, vdd_ext, est_floor;
  logic                      in_acc, out_busy, out_fire;

  bve_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign in_i.ready  = ctrl.in_wait;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_busy    = out_valid_q && !out_o.ready;
  assign out_fire    = ctrl.out_load && !out_busy;
  assign out_o.valid = out_valid_q;
  assign out_o.battery_millivolts = out_data_q;
  assign cfg_i.ready = 1'b1;

  assign status.in_valid = in_i.valid;
  assign status.out_busy = out_busy;
  assign status.filt_low = filt_q < bve_pkg::LOAD_LIMIT_MV;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= bve_pkg::CAL_RESET;
      off_q <= bve_pkg::OFF_RESET;
      wgt_q <= bve_pkg::WGT_RESET;
    end else if (cfg_i.valid) begin
      unique case (bve_pkg::cfg_reg_e'(cfg_i.index))
        bve_pkg::REG_CAL: cal_q <= cfg_i.data[bve_pkg::CalW-1:0];
        bve_pkg::REG_OFF: off_q <= cfg_i.data[bve_pkg::OffW-1:0];
        bve_pkg::REG_WGT: wgt_q <= cfg_i.data[bve_pkg::WgtW-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (ctrl.mul_sel)
      bve_pkg::MUL_CAL: begin
        mul_a = bve_pkg::MulAW'(cal_q);
        mul_b = bve_pkg::REF_MV;
      end
      bve_pkg::MUL_BAT: begin
        mul_a = bve_pkg::MulAW'(bat_q);
        mul_b = bve_pkg::GAIN_Q12;
      end
      bve_pkg::MUL_VDD: begin
        mul_a = vdd_q;
        mul_b = prod_q[bve_pkg::MulBW-1:0];
      end
      bve_pkg::MUL_NEW: begin
        mul_a = bve_pkg::MulAW'(est_q);
        mul_b = bve_pkg::MulBW'(wgt_q);
      end
      bve_pkg::MUL_OLD: begin
        mul_a = bve_pkg::MulAW'(filt_q);
        mul_b = bve_pkg::MulBW'(bve_pkg::WGT_ONE - {1'b0, wgt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = bve_pkg::ProdW'(mul_a) * bve_pkg::ProdW'(mul_b);

  // one restoring divide step
  assign rem_sh   = {rem_q, quo_q[bve_pkg::VddW-1]};
  assign rem_diff = {1'b0, rem_sh} - (bve_pkg::RemW+2)'(ref_q);

  // raw estimate, floored at the supply and saturated
  assign est_sum   = SumW'(prod_q >> Shift) + SumW'(off_q);
  assign vdd_ext   = SumW'(vdd_q);
  assign est_floor = (est_sum < vdd_ext) ? vdd_ext : est_sum;
  assign est_d     = (est_floor > MvMax) ? '1 : est_floor[bve_pkg::MvW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ref_q <= in_i.reference_raw;
      bat_q <= in_i.battery_raw;
    end
    if (ctrl.mul_sel != bve_pkg::MUL_NONE) begin
      prod_q <= ctrl.mul_acc ? prod_q + mul_p : mul_p;
    end
    if (ctrl.div_load) begin
      quo_q <= prod_q[bve_pkg::VddW-1:0];
      rem_q <= '0;
    end else if (ctrl.div_step) begin
      if (!rem_diff[bve_pkg::RemW+1]) begin
        rem_q <= rem_diff[bve_pkg::RemW-1:0];
        quo_q <= {quo_q[bve_pkg::VddW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[bve_pkg::RemW-1:0];
        quo_q <= {quo_q[bve_pkg::VddW-2:0], 1'b0};
      end
    end
    // failed reference conversion reads as zero supply
    if (ctrl.vdd_load) begin
      vdd_q <= (ref_q == '0) ? '0 : quo_q;
    end
    if (ctrl.est_load) begin
      est_q <= est_d;
    end
    if (out_fire) begin
      out_data_q <= filt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.filt_load) begin
        filt_q <= est_q;
      end else if (ctrl.filt_blend) begin
        filt_q <= prod_q[bve_pkg::WgtW +: bve_pkg::MvW];
      end
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // remainder stays below a nonzero divisor throughout the division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.div_step && ref_q != '0) |=> rem_q < ref_q)
    else $error("divider remainder not below divisor");

  // a blend never exceeds both of its inputs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.filt_blend |=> (filt_q <= $past(est_q) || filt_q <= $past(filt_q)))
    else $error("filter blend out of range");

  // a new result only appears after the output step handed it over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(out_fire))
    else $error("result raised without output step");

  // no request is taken while a divide is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.div_step |-> !in_i.ready)
    else $error("request taken during divide");

endmodule

// ===== sim/battery_voltage_estimator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_voltage_estimator_tb
// Self-checking bench for the supply-compensated battery estimator. Each
// measurement request is predicted in-bench (supply millivolts from the
// reference reading, scaled battery estimate, then filter load or blend) and
// every result is compared with the oldest prediction. Directed corners come
// first, then random phases under changing register settings, with bursty
// requests and a stalling result sink.
// ----------------------------------------------------------------------------
module battery_voltage_estimator_tb;

  localparam logic [bve_pkg::CfgIdxW-1:0] REG_UNUSED = 2'd3;  // no register behind it

  localparam longint unsigned SUPPLY_AT_CAL_MV = 3000;
  localparam longint unsigned DIVIDER_GAIN_Q12 = 6185;
  localparam longint unsigned RELOAD_BELOW_MV  = 1000;
  localparam longint unsigned MV_MAX           = 65535;
  localparam int              SCALE_SHIFT      = 12 + bve_pkg::ADC_BITS_DEF;

  localparam int RANDOM_PHASES    = 9;
  localparam int ITEMS_PER_PHASE  = 150;
  localparam int IDLE_LIMIT       = 2000;
  localparam int SETTLE_CYCLES    = 40;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SPARSE,
    READY_BURSTY
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  bve_in_if  meas_if ();
  bve_out_if result_if ();
  bve_cfg_if cfg_if ();

  battery_voltage_estimator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .in_i   (meas_if.sink),
    .out_o  (result_if.source)
  );

  // bench copy of the registers and the filter
  logic [bve_pkg::CalW-1:0] cal_setting;
  logic [bve_pkg::OffW-1:0] offset_setting;
  logic [bve_pkg::WgtW-1:0] weight_setting;
  logic [bve_pkg::MvW-1:0]  filtered_mv;

  logic [bve_pkg::MvW-1:0] expected_mv_q[$];

  int errors;
  int requests_sent;
  int results_checked;
  int register_writes;
  int filter_reloads;
  int filter_blends;
  int saturated_estimates;
  int burst_left;
  int idle_cycles;
  logic [9:0] sink_cnt;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [bve_pkg::MvW-1:0] next_filtered_mv(
    input logic [bve_pkg::RawW-1:0] reference_raw,
    input logic [bve_pkg::RawW-1:0] battery_raw
  );
    longint unsigned supply_mv;
    longint unsigned estimate_mv;
    if (reference_raw == '0) begin
      supply_mv = 0;
    end else begin
      supply_mv = (SUPPLY_AT_CAL_MV * longint'(cal_setting)) / longint'(reference_raw);
    end
    estimate_mv = ((supply_mv * longint'(battery_raw) * DIVIDER_GAIN_Q12) >> SCALE_SHIFT)
                  + longint'(offset_setting);
    if (estimate_mv < supply_mv) estimate_mv = supply_mv;
    if (estimate_mv > MV_MAX) begin
      estimate_mv = MV_MAX;
      saturated_estimates++;
    end
    if (longint'(filtered_mv) < RELOAD_BELOW_MV) begin
      filtered_mv = estimate_mv[bve_pkg::MvW-1:0];
      filter_reloads++;
    end else begin
      filtered_mv = bve_pkg::MvW'((longint'(weight_setting) * estimate_mv
                    + (256 - longint'(weight_setting)) * longint'(filtered_mv)) >> 8);
      filter_blends++;
    end
    return filtered_mv;
  endfunction

  // one measurement request; the sender idles between bursts
  task automatic send_measurement(input logic [bve_pkg::RawW-1:0] reference_raw,
                                  input logic [bve_pkg::RawW-1:0] battery_raw);
    meas_if.valid         <= 1'b1;
    meas_if.reference_raw <= reference_raw;
    meas_if.battery_raw   <= battery_raw;
    do @(posedge clk_i); while (!meas_if.ready);
    expected_mv_q.push_back(next_filtered_mv(reference_raw, battery_raw));
    requests_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      meas_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  // lower the request line and let every outstanding result come back
  task automatic wait_idle();
    if (meas_if.valid) begin
      meas_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    while (expected_mv_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [bve_pkg::CfgIdxW-1:0] index,
                                input logic [bve_pkg::CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (index)
      bve_pkg::REG_CAL: cal_setting    = value[bve_pkg::CalW-1:0];
      bve_pkg::REG_OFF: offset_setting = value[bve_pkg::OffW-1:0];
      bve_pkg::REG_WGT: weight_setting = value[bve_pkg::WgtW-1:0];
      default: ;
    endcase
    register_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_defaults_and_corners();
    send_measurement(12'd1656, 12'd2048);  // first request loads the filter
    send_measurement(12'd1656, 12'd4095);
    send_measurement(12'd1656, 12'd0);
    send_measurement(12'd0, 12'd4095);     // failed reference conversion
    send_measurement(12'd1, 12'd4095);     // huge supply, saturates
    send_measurement(12'd1, 12'd0);        // floor at a supply above 16 bits
    send_measurement(12'd4095, 12'd4095);
    send_measurement(12'd2048, 12'd1);
  endtask

  task automatic test_register_writes();
    wait_idle();
    write_register(REG_UNUSED, 12'hfff);
    write_register(bve_pkg::REG_OFF, 12'hf00);  // upper data bits are dropped
    send_measurement(12'd1656, 12'd1000);
    wait_idle();
    write_register(bve_pkg::REG_OFF, 12'h0ff);
    send_measurement(12'd1656, 12'd1000);
    wait_idle();
    write_register(bve_pkg::REG_CAL, 12'hfff);
    send_measurement(12'd1, 12'd4095);
    send_measurement(12'd4095, 12'd4095);
    wait_idle();
    write_register(bve_pkg::REG_CAL, 12'h000);  // zero supply, estimate is the offset
    send_measurement(12'd1656, 12'd4095);
  endtask

  task automatic test_filter_reload_and_hold();
    wait_idle();
    write_register(bve_pkg::REG_WGT, 12'hfff);
    write_register(bve_pkg::REG_CAL, 12'h000);
    write_register(bve_pkg::REG_OFF, 12'h0ff);
    // drag the filter below the reload threshold, then reload it
    repeat (6) send_measurement(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    wait_idle();
    write_register(bve_pkg::REG_CAL, 12'd1656);
    send_measurement(12'd1656, 12'd3000);
    wait_idle();
    write_register(bve_pkg::REG_WGT, 12'h000);  // zero weight holds the filter
    send_measurement(12'd1656, 12'd0);
    send_measurement(12'd1, 12'd4095);
    send_measurement(12'd0, 12'd0);
    wait_idle();
    write_register(bve_pkg::REG_CAL, 12'd1656);
    write_register(bve_pkg::REG_OFF, 12'd90);
    write_register(bve_pkg::REG_WGT, 12'd128);
  endtask

  task automatic test_random_measurements();
    logic [bve_pkg::RawW-1:0] reference_raw;
    logic [bve_pkg::RawW-1:0] battery_raw;
    int pick;
    int near_cal;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin
          write_register(bve_pkg::REG_CAL, 12'($urandom_range(1400, 1900)));
          write_register(bve_pkg::REG_OFF, 12'($urandom_range(0, 4095)));
          write_register(bve_pkg::REG_WGT, 12'($urandom_range(0, 4095)));
        end
        1: begin
          write_register(bve_pkg::REG_CAL, 12'h000);
          write_register(bve_pkg::REG_OFF, 12'h000);
          write_register(bve_pkg::REG_WGT, 12'h000);
        end
        2: begin
          write_register(bve_pkg::REG_CAL, 12'hfff);
          write_register(bve_pkg::REG_OFF, 12'h0ff);
          write_register(bve_pkg::REG_WGT, 12'h0ff);
        end
        default: begin
          write_register(bve_pkg::REG_CAL, 12'($urandom_range(0, 4095)));
          write_register(bve_pkg::REG_OFF, 12'($urandom_range(0, 4095)));
          write_register(bve_pkg::REG_WGT, 12'($urandom_range(0, 4095)));
        end
      endcase
      if ($urandom_range(0, 2) == 0) write_register(REG_UNUSED, 12'($urandom_range(0, 4095)));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // plausible readings near the calibration point
          near_cal = int'(cal_setting) + $urandom_range(0, 600) - 300;
          if (near_cal < 1) near_cal = 1;
          if (near_cal > 4095) near_cal = 4095;
          reference_raw = bve_pkg::RawW'(near_cal);
        end else if (pick < 80) begin
          reference_raw = bve_pkg::RawW'($urandom_range(1, 31));
        end else if (pick < 85) begin
          reference_raw = '0;
        end else begin
          reference_raw = bve_pkg::RawW'($urandom_range(0, 4095));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) battery_raw = '0;
        else if (pick == 1) battery_raw = '1;
        else battery_raw = bve_pkg::RawW'($urandom_range(0, 4095));
        send_measurement(reference_raw, battery_raw);
      end
    end
  endtask

  // result sink stalls on a pattern picked by the top two bits of a free-running counter
  always @(posedge clk_i) begin
    sink_cnt <= sink_cnt + 10'd1;
    case (sink_mode_e'(sink_cnt[9:8]))
      READY_ALWAYS: result_if.ready <= 1'b1;
      READY_RANDOM: result_if.ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: result_if.ready <= (sink_cnt[1:0] == 2'b00);
      default:      result_if.ready <= (sink_cnt[5:4] == 2'b00);
    endcase
  end

  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready) begin
      if (expected_mv_q.size() == 0) begin
        $error("battery_millivolts: expected none, got %0d", result_if.battery_millivolts);
        errors++;
      end else begin
        if (result_if.battery_millivolts !== expected_mv_q[0]) begin
          $error("battery_millivolts: expected %0d, got %0d",
                 expected_mv_q[0], result_if.battery_millivolts);
          errors++;
        end
        void'(expected_mv_q.pop_front());
        results_checked++;
      end
    end
  end

  // watchdog on cycles in which no channel moves anything
  always @(posedge clk_i) begin
    if ((meas_if.valid && meas_if.ready) || (result_if.valid && result_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("battery_voltage_estimator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    meas_if.valid         = 1'b0;
    meas_if.reference_raw = '0;
    meas_if.battery_raw   = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = bve_pkg::REG_CAL;
    cfg_if.data           = '0;
    result_if.ready       = 1'b0;
    sink_cnt              = '0;
    idle_cycles           = 0;
    errors                = 0;
    requests_sent         = 0;
    results_checked       = 0;
    register_writes       = 0;
    filter_reloads        = 0;
    filter_blends         = 0;
    saturated_estimates   = 0;
    cal_setting           = bve_pkg::CalW'(1656);
    offset_setting        = bve_pkg::OffW'(90);
    weight_setting        = bve_pkg::WgtW'(128);
    filtered_mv           = '0;
    burst_left            = $urandom_range(1, 8);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_and_corners();
    test_register_writes();
    test_filter_reload_and_hold();
    test_random_measurements();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d measurements and %0d register writes, %0d results checked",
             requests_sent, register_writes, results_checked);
    $display("filter reloads %0d, blends %0d, saturated estimates %0d",
             filter_reloads, filter_blends, saturated_estimates);
    if (errors == 0) begin
      $display("battery_voltage_estimator test passed");
    end else begin
      $display("battery_voltage_estimator test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bve_pkg.sv
rtl/core/bve_if.sv
rtl/core/bve_sequencer.sv
rtl/core/battery_voltage_estimator.sv
sim/battery_voltage_estimator_tb.sv
